[design/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Both take a label, a trigger, a check and a message, clocked on clk_i and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check in the same cycle as the trigger
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check in the cycle after the trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/aasr_pkg.sv]
package aasr_pkg;

  // Anchor scan limits
  localparam int MAX_ANCHORS = 256;
  localparam int IDX_W       = $clog2(MAX_ANCHORS);
  localparam int CONF_W      = 16;

  // Register and result widths
  localparam int AIU_W  = 9;
  localparam int EXT_W  = 14;
  localparam int POS_W  = 17;
  localparam int PIX_W  = 13;
  localparam int DIVR_W = 8;

  localparam logic [AIU_W-1:0] AIU_RESET   = 9'd200;
  localparam logic [EXT_W-1:0] EXT_RESET   = 14'd1280;
  localparam logic [AIU_W-1:0] AIU_LIMIT   = AIU_W'(MAX_ANCHORS);
  localparam logic [PIX_W-1:0] PIX_CLAMP   = 13'd8191;

  // APB register map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_ANCHORS = 1'b0;
  localparam logic REG_EXTENT  = 1'b1;

  // Exponential in Q0.32: e^(-1/256) and unity
  localparam int ACC_W = 33;
  localparam int C_W   = 32;
  localparam logic [C_W-1:0]   EXP_STEP_Q32 = 32'd4278222805;
  localparam logic [ACC_W-1:0] ONE_Q32      = 33'h1_0000_0000;
  localparam logic [64:0]      HALF_Q32     = 65'h0_8000_0000;
  localparam int EXP_BITS = 16;
  localparam int EXP_CNT_W = $clog2(EXP_BITS);

  // Weight and position arithmetic
  localparam int W_W     = 17;
  localparam int WSUM_W  = 19;
  localparam int PACC_W  = 28;
  localparam int PNUM_W  = POS_W + EXT_W - 8;
  localparam logic [PACC_W-1:0] POS_ROUND = 28'd32896;

  // Shared restoring divider
  localparam int DIV_W     = 49;
  localparam int DSR_W     = 34;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [CONF_W-1:0] max_val;
    logic [CONF_W-1:0] before_val;
    logic [CONF_W-1:0] after_val;
  } pos_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[design/aasr_fifo.sv]
module aasr_fifo
  import aasr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pos_rec_t push_rec_i,
  input  logic     pop_i,
  output pos_rec_t head_rec_o,
  output q_stat_t  stat_o
);

  pos_rec_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_rec_o   = mem_q[rd_ptr_q];

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[design/aasr_div.sv]
module aasr_div
  import aasr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dvd_q;
  logic [DSR_W-1:0]     dsr_q;
  logic [DSR_W-1:0]     rem_q;
  logic [DSR_W:0]       rem_sh;
  logic                 fits;

  // One quotient bit per cycle: shift in a dividend bit, try a subtract
  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
    end else begin
      // Pulse done on the last quotient bit
      done_q <= !start_i && busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W - 1);
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= DSR_W'(rem_sh - {1'b0, dsr_q});
        end else begin
          rem_q <= rem_sh[DSR_W-1:0];
        end
        dvd_q <= {dvd_q[DIV_W-2:0], fits};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

[design/aasr_front.sv]
module aasr_front
  import aasr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [CONF_W-1:0] confidence_i,
  input  logic              last_anchor_i,
  output logic              in_stall_o,
  input  q_stat_t           q_stat_i,
  output logic              push_o,
  output pos_rec_t          push_rec_o
);

  logic [CONF_W-1:0] max_q, max_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  count_q, count_d;
  logic [CONF_W-1:0] prev_q, prev_d;
  logic [CONF_W-1:0] before_q, before_d;
  logic [CONF_W-1:0] after_q, after_d;
  logic              capture_q, capture_d;
  logic              accept;
  logic              greater;

  // Hold the stream while the queue has no room for a result
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign greater    = $signed(confidence_i) > $signed(max_q);

  // Track the running maximum and its neighbors
  always_comb begin
    after_d  = capture_q ? confidence_i : after_q;
    max_d    = max_q;
    idx_d    = idx_q;
    before_d = before_q;
    if (greater) begin
      max_d    = confidence_i;
      idx_d    = count_q;
      before_d = prev_q;
      after_d  = '0;
    end
    capture_d = greater;
    prev_d    = confidence_i;
    count_d   = (count_q != IDX_W'(MAX_ANCHORS - 1)) ? count_q + 1'b1 : count_q;
  end

  // Push the finished position on the marked item
  assign push_o                = accept && last_anchor_i;
  assign push_rec_o.idx        = idx_d;
  assign push_rec_o.max_val    = max_d;
  assign push_rec_o.before_val = before_d;
  assign push_rec_o.after_val  = after_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= '0;
      idx_q     <= '0;
      count_q   <= '0;
      prev_q    <= '0;
      before_q  <= '0;
      after_q   <= '0;
      capture_q <= 1'b0;
    end else if (accept) begin
      if (last_anchor_i) begin
        max_q     <= '0;
        idx_q     <= '0;
        count_q   <= '0;
        prev_q    <= '0;
        before_q  <= '0;
        after_q   <= '0;
        capture_q <= 1'b0;
      end else begin
        max_q     <= max_d;
        idx_q     <= idx_d;
        count_q   <= count_d;
        prev_q    <= prev_d;
        before_q  <= before_d;
        after_q   <= after_d;
        capture_q <= capture_d;
      end
    end
  end

endmodule

[design/aasr_back.sv]
module aasr_back
  import aasr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AIU_W-1:0] anchors_in_use_i,
  input  logic [EXT_W-1:0] image_extent_i,
  input  q_stat_t          q_stat_i,
  input  pos_rec_t         head_rec_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IDX_W-1:0] best_anchor_o,
  output logic [POS_W-1:0] refined_pos_o,
  output logic [PIX_W-1:0] pixel_coord_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_POS,
    ST_SUM_POS,
    ST_MUL_PIX,
    ST_PIX_GO,
    ST_PIX_WAIT,
    ST_DONE
  } st_e;

  typedef enum logic [1:0] {
    PH_E0,
    PH_E2,
    PH_SQ
  } phase_e;

  st_e                  state_q;
  phase_e               phase_q;
  logic [EXP_CNT_W-1:0] bit_q;
  logic [1:0]           wsel_q;
  logic [IDX_W-1:0]     idx_q;
  logic [CONF_W-1:0]    d0_q;
  logic [CONF_W-1:0]    d2_q;
  logic [ACC_W-1:0]     acc0_q;
  logic [ACC_W-1:0]     acc2_q;
  logic [C_W-1:0]       c_q;
  logic [W_W-1:0]       w_q [3];
  logic [PACC_W-1:0]    pos_acc_q;
  logic [POS_W-1:0]     refined_q;
  logic [PNUM_W-1:0]    pix_num_q;
  logic [PIX_W-1:0]     pixel_q;
  logic                 out_valid_q;
  logic [IDX_W-1:0]     best_q;
  logic [POS_W-1:0]     refined_out_q;
  logic [PIX_W-1:0]     pixel_out_q;

  logic [AIU_W-1:0]     n_anchors;
  logic [DIVR_W-1:0]    pix_divisor;
  logic                 do_refine;
  logic [CONF_W:0]      diff0, diff2;
  logic [ACC_W-1:0]     mul_a;
  logic [C_W-1:0]       mul_b;
  logic [64:0]          prod;
  logic [64:0]          prod_rnd;
  logic [ACC_W-1:0]     rnd;
  logic [DSR_W-1:0]     e_sum;
  logic [ACC_W-1:0]     e_sel;
  logic [WSUM_W-1:0]    w_sum;
  logic [PACC_W-1:0]    pos_sum;
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DSR_W-1:0]     div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quot;
  logic                 out_free;

  // Effective anchor count and pixel divisor
  assign n_anchors   = (anchors_in_use_i > AIU_LIMIT) ? AIU_LIMIT : anchors_in_use_i;
  assign pix_divisor = (n_anchors >= AIU_W'(2)) ? DIVR_W'(n_anchors - 1'b1) : DIVR_W'(1);

  // Classify the queue head: refine only away from both ends
  assign do_refine = (head_rec_i.idx > IDX_W'(1)) &&
                     (({1'b0, head_rec_i.idx} + 1'b1) < n_anchors);
  assign diff0 = {head_rec_i.max_val[CONF_W-1], head_rec_i.max_val} -
                 {head_rec_i.before_val[CONF_W-1], head_rec_i.before_val};
  assign diff2 = {head_rec_i.max_val[CONF_W-1], head_rec_i.max_val} -
                 {head_rec_i.after_val[CONF_W-1], head_rec_i.after_val};

  assign pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_EXP: begin
        case (phase_q)
          PH_E0:   mul_a = acc0_q;
          PH_E2:   mul_a = acc2_q;
          default: mul_a = {1'b0, c_q};
        endcase
        mul_b = c_q;
      end
      ST_MUL_POS: begin
        mul_a = ACC_W'(w_sum);
        mul_b = C_W'(idx_q);
      end
      ST_MUL_PIX: begin
        mul_a = ACC_W'(refined_q);
        mul_b = C_W'(image_extent_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = 65'(mul_a) * 65'(mul_b);
  assign prod_rnd = prod + HALF_Q32;
  assign rnd      = prod_rnd[64:32];

  // Weight numerators and divider operands
  assign e_sum = DSR_W'(acc0_q) + DSR_W'(ONE_Q32) + DSR_W'(acc2_q);
  always_comb begin
    case (wsel_q)
      2'd0:    e_sel = acc0_q;
      2'd1:    e_sel = ONE_Q32;
      default: e_sel = acc2_q;
    endcase
  end

  always_comb begin
    if (state_q == ST_PIX_GO) begin
      div_dividend = DIV_W'(pix_num_q);
      div_divisor  = DSR_W'(pix_divisor);
    end else begin
      div_dividend = {e_sel, 16'd0} + DIV_W'(e_sum >> 1);
      div_divisor  = e_sum;
    end
  end
  assign div_start = (state_q == ST_DIV_GO) || (state_q == ST_PIX_GO);

  assign w_sum   = WSUM_W'(w_q[0]) + WSUM_W'(w_q[1]) + WSUM_W'(w_q[2]);
  assign pos_sum = pos_acc_q + PACC_W'(w_q[2]) + POS_ROUND - PACC_W'(w_q[0]);

  assign out_free = !out_valid_q || !out_stall_i;

  aasr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Sequencer for one position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_E0;
      bit_q         <= '0;
      wsel_q        <= '0;
      idx_q         <= '0;
      d0_q          <= '0;
      d2_q          <= '0;
      acc0_q        <= ONE_Q32;
      acc2_q        <= ONE_Q32;
      c_q           <= EXP_STEP_Q32;
      w_q[0]        <= '0;
      w_q[1]        <= '0;
      w_q[2]        <= '0;
      pos_acc_q     <= '0;
      refined_q     <= '0;
      pix_num_q     <= '0;
      pixel_q       <= '0;
      out_valid_q   <= 1'b0;
      best_q        <= '0;
      refined_out_q <= '0;
      pixel_out_q   <= '0;
    end else begin
      // Drop the output once taken, unless the next one replaces it
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            idx_q  <= head_rec_i.idx;
            d0_q   <= diff0[CONF_W] ? '0 : diff0[CONF_W-1:0];
            d2_q   <= diff2[CONF_W] ? '0 : diff2[CONF_W-1:0];
            acc0_q <= ONE_Q32;
            acc2_q <= ONE_Q32;
            c_q    <= EXP_STEP_Q32;
            bit_q  <= '0;
            phase_q <= PH_E0;
            wsel_q <= '0;
            if (do_refine) begin
              state_q <= ST_EXP;
            end else begin
              refined_q <= {1'b0, head_rec_i.idx, 8'd0};
              state_q   <= ST_MUL_PIX;
            end
          end
        end
        ST_EXP: begin
          case (phase_q)
            PH_E0: begin
              if (d0_q[bit_q]) begin
                acc0_q <= rnd;
              end
              phase_q <= PH_E2;
            end
            PH_E2: begin
              if (d2_q[bit_q]) begin
                acc2_q <= rnd;
              end
              phase_q <= PH_SQ;
            end
            default: begin
              c_q     <= rnd[C_W-1:0];
              phase_q <= PH_E0;
              if (bit_q == EXP_CNT_W'(EXP_BITS - 1)) begin
                state_q <= ST_DIV_GO;
              end else begin
                bit_q <= bit_q + 1'b1;
              end
            end
          endcase
        end
        ST_DIV_GO: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            w_q[wsel_q] <= div_quot[W_W-1:0];
            if (wsel_q == 2'd2) begin
              state_q <= ST_MUL_POS;
            end else begin
              wsel_q  <= wsel_q + 1'b1;
              state_q <= ST_DIV_GO;
            end
          end
        end
        ST_MUL_POS: begin
          pos_acc_q <= prod[PACC_W-1:0];
          state_q   <= ST_SUM_POS;
        end
        ST_SUM_POS: begin
          refined_q <= pos_sum[POS_W+7:8];
          state_q   <= ST_MUL_PIX;
        end
        ST_MUL_PIX: begin
          pix_num_q <= prod[POS_W+EXT_W-1:8];
          state_q   <= ST_PIX_GO;
        end
        ST_PIX_GO: begin
          state_q <= ST_PIX_WAIT;
        end
        ST_PIX_WAIT: begin
          if (div_done) begin
            pixel_q <= (|div_quot[DIV_W-1:PIX_W]) ? PIX_CLAMP : div_quot[PIX_W-1:0];
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            best_q        <= idx_q;
            refined_out_q <= refined_q;
            pixel_out_q   <= pixel_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_anchor_o = best_q;
  assign refined_pos_o = refined_out_q;
  assign pixel_coord_o = pixel_out_q;

endmodule

[design/anchor_argmax_softmax_refine.sv]
// Lane-anchor argmax with three-point softmax refinement.
// Input channel (in_valid_i / in_stall_o): one signed Q8.8 confidence per item,
// last_anchor_i marks the final anchor of a lane position. The scan side takes
// one item per cycle and holds in_stall_o only while the two-entry result queue
// is full.
// Output channel (out_valid_o / out_stall_i): one item per position carrying
// best_anchor_o, refined_pos_o (unsigned Q9.8) and pixel_coord_o (clamped to 8191).
// The result stays registered while out_stall_i is high; the compute side
// keeps working on the next queued position meanwhile.
// Per position the compute side runs the exponentials on one shared multiplier,
// then three weight divides and one pixel divide on one shared divider when
// refinement applies, and only the pixel multiply and divide when the maximum
// sits near either end. The scan side keeps taking items while the compute side
// works, as long as the result queue has room.
// Reset clears the scan state, the queue and the output; anchors_in_use comes
// up at 200 and image_extent at 1280. Registers are written over APB at byte
// address 0 (anchors_in_use) and 4 (image_extent); the user must write them only
// while the block is idle, as the block itself does not enforce it.
`include "assert_macros.svh"

module anchor_argmax_softmax_refine
  import aasr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CONF_W-1:0] confidence_i,
  input  logic              last_anchor_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  best_anchor_o,
  output logic [POS_W-1:0]  refined_pos_o,
  output logic [PIX_W-1:0]  pixel_coord_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [AIU_W-1:0] anchors_q;
  logic [EXT_W-1:0] extent_q;
  logic             cfg_write;
  logic             push;
  pos_rec_t         push_rec;
  logic             pop;
  pos_rec_t         head_rec;
  q_stat_t          q_stat;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchors_q <= AIU_RESET;
      extent_q  <= EXT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ANCHORS: anchors_q <= pwdata[AIU_W-1:0];
        REG_EXTENT:  extent_q  <= pwdata[EXT_W-1:0];
        default:     anchors_q <= anchors_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ANCHORS: prdata = DATA_W'(anchors_q);
      REG_EXTENT:  prdata = DATA_W'(extent_q);
      default:     prdata = '0;
    endcase
  end

  aasr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .confidence_i  (confidence_i),
    .last_anchor_i (last_anchor_i),
    .in_stall_o    (in_stall_o),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_rec_o    (push_rec)
  );

  aasr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_rec_o (head_rec),
    .stat_o     (q_stat)
  );

  aasr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .anchors_in_use_i (anchors_q),
    .image_extent_i   (extent_q),
    .q_stat_i         (q_stat),
    .head_rec_i       (head_rec),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .best_anchor_o    (best_anchor_o),
    .refined_pos_o    (refined_pos_o),
    .pixel_coord_o    (pixel_coord_o)
  );

  // A finished position never lands on a full queue
  `ASSERT_SAME(a_no_overflow, push, !q_stat.full, "result pushed into a full queue")
  // The compute side never pulls from an empty queue
  `ASSERT_SAME(a_no_underflow, pop, !q_stat.empty, "pop from an empty queue")
  // A maximum at either of the two lowest indices is never refined
  `ASSERT_SAME(a_edge_pos, out_valid_o && (best_anchor_o < IDX_W'(2)),
               refined_pos_o == {1'b0, best_anchor_o, 8'd0}, "edge anchor was refined")
  // Index zero maps to pixel zero
  `ASSERT_SAME(a_zero_pix, out_valid_o && (best_anchor_o == '0),
               pixel_coord_o == '0, "index zero gave a nonzero pixel")

endmodule
